// ===== rtl/qau_pkg.sv =====
`timescale 1ns / 1ps

package qau_pkg;

    // Fixed-point format of every operand and result component.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // Operation codes carried on the func field.
    localparam logic [3:0] FN_ADD   = 4'd0;
    localparam logic [3:0] FN_SUB   = 4'd1;
    localparam logic [3:0] FN_DOT   = 4'd2;
    localparam logic [3:0] FN_CROSS = 4'd3;
    localparam logic [3:0] FN_SCALE = 4'd4;
    localparam logic [3:0] FN_PROD  = 4'd5;
    localparam logic [3:0] FN_CONJ  = 4'd6;
    localparam logic [3:0] FN_NORM  = 4'd7;
    localparam logic [3:0] FN_INV   = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Full product of two components and the wide pre-saturation lane value.
    localparam int PROD_W   = 2 * DATA_W;
    localparam int VAL_W    = 67 - FRAC_BITS;
    localparam int DIRECT_W = DATA_W + 2;

    // Squared norm, divider numerator and dividend widths.
    localparam int N2_W  = 66 - FRAC_BITS;
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int D_W   = ((NUM_W > N2_W) ? NUM_W : N2_W) + 1;
    localparam int RQ_W  = D_W - DATA_W;

    // Sum of the raw squares for the norm, one bit above 64 for the carry.
    localparam int SQ_W = PROD_W + 1;

    // Iterative units: 32 result bits, two per pipeline stage.
    localparam int ROOT_BITS       = 32;
    localparam int STEPS_PER_STAGE = 2;
    localparam int ITER_STAGES     = ROOT_BITS / STEPS_PER_STAGE;

    // Pipeline stage positions.
    localparam int STG_MUL  = 0;
    localparam int STG_SUM  = 1;
    localparam int STG_N2   = 2;
    localparam int STG_PREP = 3;
    localparam int STG_ITER = 4;
    localparam int STG_OUT  = STG_ITER + ITER_STAGES;
    localparam int N_STG    = STG_OUT + 1;

    // Sign of each Hamilton product term, indexed [lane][term].
    localparam logic [3:0][3:0] PROD_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    typedef struct packed {
        logic [3:0] term_use;
        logic [3:0] term_neg;
        logic       use_direct;
    } lane_ctl_t;

endpackage

// ===== rtl/qau_lane.sv =====
`timescale 1ns / 1ps

module qau_lane (
    input  logic                                clk,
    input  logic                                load_mul,
    input  logic                                load_sum,
    input  qau_pkg::lane_ctl_t                  ctl,
    input  logic signed [qau_pkg::DATA_W-1:0]   mul_p [4],
    input  logic signed [qau_pkg::DATA_W-1:0]   mul_q [4],
    input  logic signed [qau_pkg::DIRECT_W-1:0] direct,
    output logic signed [qau_pkg::PROD_W-1:0]   raw_sq,
    output logic signed [qau_pkg::VAL_W-1:0]    value
);

    logic signed [qau_pkg::PROD_W-1:0]   prod_reg [4];
    qau_pkg::lane_ctl_t                  ctl_reg;
    logic signed [qau_pkg::DIRECT_W-1:0] direct_reg;
    logic signed [qau_pkg::VAL_W-1:0]    value_reg;
    logic signed [qau_pkg::VAL_W-1:0]    value_next;

    // Round to nearest with ties upward: add half an LSB, then floor shift.
    function automatic logic signed [qau_pkg::VAL_W-1:0] round_prod(
        input logic signed [qau_pkg::PROD_W-1:0] p
    );
        logic signed [qau_pkg::PROD_W:0] x;
        x = $signed({p[qau_pkg::PROD_W-1], p})
            + ($signed((qau_pkg::PROD_W+1)'(1)) <<< (qau_pkg::FRAC_BITS - 1));
        return qau_pkg::VAL_W'(x >>> qau_pkg::FRAC_BITS);
    endfunction

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= mul_p[j] * mul_q[j];
            end
            ctl_reg    <= ctl;
            direct_reg <= direct;
        end
    end

    always_comb
    begin
        logic signed [qau_pkg::VAL_W-1:0] acc;
        logic signed [qau_pkg::VAL_W-1:0] term;
        acc = '0;
        for (int j = 0; j < 4; j++)
        begin
            term = round_prod(prod_reg[j]);
            if (ctl_reg.term_use[j])
            begin
                if (ctl_reg.term_neg[j])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        if (ctl_reg.use_direct)
        begin
            value_next = qau_pkg::VAL_W'(direct_reg);
        end
        else
        begin
            value_next = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            value_reg <= value_next;
        end
    end

    assign raw_sq = prod_reg[0];
    assign value  = value_reg;

endmodule

// ===== rtl/qau_div.sv =====
`timescale 1ns / 1ps

module qau_div (
    input  logic                              clk,
    input  logic [qau_pkg::ITER_STAGES:0]     load,
    input  logic [qau_pkg::N2_W-1:0]          n2,
    input  logic [qau_pkg::DATA_W-1:0]        mag_in,
    input  logic                              neg_in,
    output logic [qau_pkg::DATA_W-1:0]        quot,
    output logic                              neg,
    output logic                              ovf,
    output logic                              zero
);

    localparam int LAST = qau_pkg::ITER_STAGES;

    logic [qau_pkg::N2_W-1:0]   rem_reg  [LAST+1];
    logic [qau_pkg::DATA_W-1:0] dl_reg   [LAST+1];
    logic [qau_pkg::DATA_W-1:0] q_reg    [LAST+1];
    logic [qau_pkg::N2_W-1:0]   n2_reg   [LAST+1];
    logic                       neg_reg  [LAST+1];
    logic                       ovf_reg  [LAST+1];
    logic                       zero_reg [LAST+1];

    // Dividend is the shifted magnitude plus half the divisor, for rounding.
    logic [qau_pkg::D_W-1:0]  dividend;
    logic [qau_pkg::RQ_W-1:0] rem_top;

    always_comb
    begin
        dividend = ({{(qau_pkg::D_W - qau_pkg::DATA_W){1'b0}}, mag_in} << qau_pkg::FRAC_BITS)
                   + qau_pkg::D_W'(n2 >> 1);
        rem_top  = dividend[qau_pkg::D_W-1:qau_pkg::DATA_W];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            rem_reg[0]  <= qau_pkg::N2_W'(rem_top);
            dl_reg[0]   <= dividend[qau_pkg::DATA_W-1:0];
            q_reg[0]    <= '0;
            n2_reg[0]   <= n2;
            neg_reg[0]  <= neg_in;
            // A quotient of 2^32 or more can only saturate.
            ovf_reg[0]  <= (qau_pkg::N2_W'(rem_top) >= n2);
            zero_reg[0] <= (n2 == '0);
        end
    end

    for (genvar s = 1; s <= LAST; s++)
    begin : g_stage
        logic [qau_pkg::N2_W-1:0]   rem_next;
        logic [qau_pkg::DATA_W-1:0] dl_next;
        logic [qau_pkg::DATA_W-1:0] q_next;

        always_comb
        begin
            logic [qau_pkg::N2_W:0] trial;
            rem_next = rem_reg[s-1];
            dl_next  = dl_reg[s-1];
            q_next   = q_reg[s-1];
            for (int t = 0; t < qau_pkg::STEPS_PER_STAGE; t++)
            begin
                trial = {rem_next, dl_next[qau_pkg::DATA_W-1]};
                if (trial >= {1'b0, n2_reg[s-1]})
                begin
                    trial  = trial - {1'b0, n2_reg[s-1]};
                    q_next = {q_next[qau_pkg::DATA_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[qau_pkg::DATA_W-2:0], 1'b0};
                end
                rem_next = trial[qau_pkg::N2_W-1:0];
                dl_next  = {dl_next[qau_pkg::DATA_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                rem_reg[s]  <= rem_next;
                dl_reg[s]   <= dl_next;
                q_reg[s]    <= q_next;
                n2_reg[s]   <= n2_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    assign quot = q_reg[LAST];
    assign neg  = neg_reg[LAST];
    assign ovf  = ovf_reg[LAST];
    assign zero = zero_reg[LAST];

endmodule

// ===== rtl/qau_sqrt.sv =====
`timescale 1ns / 1ps

module qau_sqrt (
    input  logic                            clk,
    input  logic [qau_pkg::ITER_STAGES:0]   load,
    input  logic [qau_pkg::SQ_W-1:0]        sum_in,
    output logic [qau_pkg::DATA_W:0]        mag
);

    localparam int LAST = qau_pkg::ITER_STAGES;

    typedef struct packed {
        logic [qau_pkg::PROD_W-1:0] rem;
        logic [qau_pkg::PROD_W-1:0] root;
    } sq_state_t;

    sq_state_t st_reg    [LAST+1];
    logic      carry_reg [LAST+1];

    function automatic sq_state_t sqrt_step(input sq_state_t s, input int idx);
        logic [qau_pkg::PROD_W-1:0] bitv;
        logic [qau_pkg::PROD_W-1:0] trial;
        sq_state_t                  r;
        bitv  = qau_pkg::PROD_W'(1) << (qau_pkg::PROD_W - 2 - 2 * idx);
        trial = s.root + bitv;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + bitv;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            st_reg[0].rem  <= sum_in[qau_pkg::PROD_W-1:0];
            st_reg[0].root <= '0;
            carry_reg[0]   <= sum_in[qau_pkg::PROD_W];
        end
    end

    for (genvar s = 1; s <= LAST; s++)
    begin : g_stage
        sq_state_t st_next;

        always_comb
        begin
            st_next = st_reg[s-1];
            for (int t = 0; t < qau_pkg::STEPS_PER_STAGE; t++)
            begin
                st_next = sqrt_step(st_next, (s - 1) * qau_pkg::STEPS_PER_STAGE + t);
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                st_reg[s]    <= st_next;
                carry_reg[s] <= carry_reg[s-1];
            end
        end
    end

    // An overflowing sum of squares is forced past the 32-bit limit.
    assign mag = carry_reg[LAST] ? {1'b1, {qau_pkg::DATA_W{1'b0}}}
                                 : {1'b0, st_reg[LAST].root[qau_pkg::DATA_W-1:0]};

endmodule

// ===== rtl/quaternion_arithmetic_unit.sv =====
`timescale 1ns / 1ps

// Quaternion arithmetic unit on signed Q16.16 operands. One transaction carries two
// quaternions, a scalar and an operation code, and yields one quaternion and a status.
// The unit is a 21-stage pipeline that takes a new transaction every clock cycle while
// the output side does not stall. That depth is set by the 32-bit square root of the
// squared norm and the four reciprocal divisions of the inverse, which each resolve two
// result bits per stage over sixteen stages, behind a multiplier stage, a rounding and
// summing stage, a squared-norm stage and a divider set-up stage and ahead of an output
// stage. Each stage moves on as soon as the one after it is empty or moving, so bubbles
// close up and new transactions are still taken while a finished result waits at the
// output.
module quaternion_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] r_w,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic [1:0]  status
);

    localparam int PASS_DEPTH = qau_pkg::STG_OUT - qau_pkg::STG_N2;
    localparam int DW         = qau_pkg::DATA_W;
    localparam int VW         = qau_pkg::VAL_W;

    typedef struct packed {
        logic [31:0] v;
        logic        f;
    } sat_res_t;

    typedef struct packed {
        logic [3:0]                  op;
        logic [3:0][VW-1:0]          val;
    } pass_t;

    // Saturate a wide lane value to 32 bits and flag it when clipped.
    function automatic sat_res_t sat32(input logic signed [VW-1:0] x);
        sat_res_t r;
        if (x > $signed(VW'(32'sh7fff_ffff)))
        begin
            r.v = 32'h7fff_ffff;
            r.f = 1'b1;
        end
        else if (x < $signed(VW'(-33'sd2147483648)))
        begin
            r.v = 32'h8000_0000;
            r.f = 1'b1;
        end
        else
        begin
            r.v = x[31:0];
            r.f = 1'b0;
        end
        return r;
    endfunction

    // Handshake: each stage loads when it is empty or its content moves on.
    logic [qau_pkg::N_STG-1:0] valid_reg;
    logic [qau_pkg::N_STG:0]   load;

    always_comb
    begin
        load[qau_pkg::N_STG] = out_ready;
        for (int i = qau_pkg::N_STG - 1; i >= 0; i--)
        begin
            load[i] = ~valid_reg[i] | load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < qau_pkg::N_STG; i++)
            begin
                if (load[i])
                begin
                    if (i == 0)
                    begin
                        valid_reg[i] <= in_valid;
                    end
                    else
                    begin
                        valid_reg[i] <= valid_reg[i-1];
                    end
                end
            end
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[qau_pkg::STG_OUT];

    // Operand selection for the four lanes. Lane k is result component k and owns four
    // multipliers; the Hamilton product pairs a[j] with b[k xor j], and the cross and dot
    // products are the same arrangement with the terms they lack switched off.
    logic signed [DW-1:0] a_in [4];
    logic signed [DW-1:0] b_in [4];

    assign a_in[0] = a_w;
    assign a_in[1] = a_x;
    assign a_in[2] = a_y;
    assign a_in[3] = a_z;
    assign b_in[0] = b_w;
    assign b_in[1] = b_x;
    assign b_in[2] = b_y;
    assign b_in[3] = b_z;

    logic signed [DW-1:0]                mul_p  [4][4];
    logic signed [DW-1:0]                mul_q  [4][4];
    qau_pkg::lane_ctl_t                  ctl    [4];
    logic signed [qau_pkg::DIRECT_W-1:0] direct [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ctl[k].use_direct = 1'b0;
            direct[k]         = '0;
            for (int j = 0; j < 4; j++)
            begin
                mul_p[k][j]       = a_in[2'(j)];
                mul_q[k][j]       = b_in[2'(k ^ j)];
                ctl[k].term_use[j] = 1'b0;
                ctl[k].term_neg[j] = qau_pkg::PROD_NEG[k][j];
                unique case (func)
                    qau_pkg::FN_PROD:
                    begin
                        ctl[k].term_use[j] = 1'b1;
                    end
                    qau_pkg::FN_CROSS:
                    begin
                        ctl[k].term_use[j] = (k != 0) && (j != 0) && (j != k);
                    end
                    qau_pkg::FN_DOT:
                    begin
                        ctl[k].term_use[j] = (k == 0) && (j != 0);
                    end
                    qau_pkg::FN_SCALE:
                    begin
                        mul_p[k][j]        = a_in[2'(k)];
                        mul_q[k][j]        = scalar;
                        ctl[k].term_use[j] = (j == 0);
                        ctl[k].term_neg[j] = 1'b0;
                    end
                    qau_pkg::FN_NORM, qau_pkg::FN_INV:
                    begin
                        mul_p[k][j]        = a_in[2'(k)];
                        mul_q[k][j]        = a_in[2'(k)];
                        ctl[k].term_use[j] = (j == 0);
                        ctl[k].term_neg[j] = 1'b0;
                    end
                    default:
                    begin
                        ctl[k].term_use[j] = 1'b0;
                    end
                endcase
            end
            unique case (func)
                qau_pkg::FN_ADD:
                begin
                    ctl[k].use_direct = 1'b1;
                    direct[k] = qau_pkg::DIRECT_W'(a_in[k]) + qau_pkg::DIRECT_W'(b_in[k]);
                end
                qau_pkg::FN_SUB:
                begin
                    ctl[k].use_direct = 1'b1;
                    direct[k] = qau_pkg::DIRECT_W'(a_in[k]) - qau_pkg::DIRECT_W'(b_in[k]);
                end
                qau_pkg::FN_CONJ:
                begin
                    ctl[k].use_direct = 1'b1;
                    if (k == 0)
                    begin
                        direct[k] = qau_pkg::DIRECT_W'(a_in[k]);
                    end
                    else
                    begin
                        direct[k] = -qau_pkg::DIRECT_W'(a_in[k]);
                    end
                end
                qau_pkg::FN_DOT, qau_pkg::FN_CROSS, qau_pkg::FN_SCALE, qau_pkg::FN_PROD,
                qau_pkg::FN_NORM, qau_pkg::FN_INV:
                begin
                    ctl[k].use_direct = 1'b0;
                end
                default:
                begin
                    // Unused codes give a zero quaternion with status ok.
                    ctl[k].use_direct = 1'b1;
                end
            endcase
        end
    end

    logic signed [qau_pkg::PROD_W-1:0] raw_sq   [4];
    logic signed [VW-1:0]              lane_val [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        qau_lane u_lane (
            .clk      (clk),
            .load_mul (load[qau_pkg::STG_MUL]),
            .load_sum (load[qau_pkg::STG_SUM]),
            .ctl      (ctl[k]),
            .mul_p    (mul_p[k]),
            .mul_q    (mul_q[k]),
            .direct   (direct[k]),
            .raw_sq   (raw_sq[k]),
            .value    (lane_val[k])
        );
    end

    // Operation code and first operand travel alongside the lanes to the divider set-up.
    logic [3:0]           op_s0_reg, op_s1_reg;
    logic signed [DW-1:0] a_s0_reg [4];
    logic signed [DW-1:0] a_s1_reg [4];
    logic signed [DW-1:0] a_s2_reg [4];
    logic [qau_pkg::SQ_W-1:0] sq_s1_reg, sq_s1_next;
    logic [qau_pkg::SQ_W-1:0] sq_s2_reg;
    logic [qau_pkg::N2_W-1:0] n2_s2_reg;
    logic signed [VW-1:0]     n2_sum;
    pass_t                    pass_reg [PASS_DEPTH];
    pass_t                    pass_next;

    // The raw squares of a are non-negative, so they add as unsigned with one carry bit.
    always_comb
    begin
        sq_s1_next = {1'b0, raw_sq[0]} + {1'b0, raw_sq[1]}
                   + {1'b0, raw_sq[2]} + {1'b0, raw_sq[3]};
        n2_sum     = lane_val[0] + lane_val[1] + lane_val[2] + lane_val[3];
        pass_next.op = op_s1_reg;
        for (int k = 0; k < 4; k++)
        begin
            pass_next.val[k] = lane_val[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[qau_pkg::STG_MUL])
        begin
            op_s0_reg <= func;
            a_s0_reg  <= a_in;
        end
        if (load[qau_pkg::STG_SUM])
        begin
            op_s1_reg <= op_s0_reg;
            a_s1_reg  <= a_s0_reg;
            sq_s1_reg <= sq_s1_next;
        end
        if (load[qau_pkg::STG_N2])
        begin
            a_s2_reg    <= a_s1_reg;
            sq_s2_reg   <= sq_s1_reg;
            n2_s2_reg   <= n2_sum[qau_pkg::N2_W-1:0];
            pass_reg[0] <= pass_next;
        end
        for (int i = 1; i < PASS_DEPTH; i++)
        begin
            if (load[qau_pkg::STG_N2 + i])
            begin
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // Inverse: each component of the conjugate divided by the squared norm.
    logic [DW-1:0] div_mag  [4];
    logic          div_sign [4];
    logic [DW-1:0] div_q    [4];
    logic          div_neg  [4];
    logic          div_ovf  [4];
    logic          div_zero [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            div_mag[k] = a_s2_reg[k][DW-1] ? DW'(-a_s2_reg[k]) : DW'(a_s2_reg[k]);
            if (k == 0)
            begin
                div_sign[k] = a_s2_reg[k][DW-1];
            end
            else
            begin
                div_sign[k] = ~a_s2_reg[k][DW-1] && (a_s2_reg[k] != '0);
            end
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_div
        qau_div u_div (
            .clk    (clk),
            .load   (load[qau_pkg::STG_OUT-1:qau_pkg::STG_PREP]),
            .n2     (n2_s2_reg),
            .mag_in (div_mag[k]),
            .neg_in (div_sign[k]),
            .quot   (div_q[k]),
            .neg    (div_neg[k]),
            .ovf    (div_ovf[k]),
            .zero   (div_zero[k])
        );
    end

    logic [DW:0] root_mag;

    qau_sqrt u_sqrt (
        .clk    (clk),
        .load   (load[qau_pkg::STG_OUT-1:qau_pkg::STG_PREP]),
        .sum_in (sq_s2_reg),
        .mag    (root_mag)
    );

    // Merge: pick each component's source, saturate and form the status.
    pass_t                last;
    logic signed [VW-1:0] fin  [4];
    sat_res_t             sat  [4];
    logic [1:0]           status_next;

    always_comb
    begin
        logic [DW:0]          qm;
        logic signed [VW-1:0] t;
        logic                 any_sat;
        last    = pass_reg[PASS_DEPTH-1];
        any_sat = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            qm = div_ovf[k] ? {1'b1, {DW{1'b0}}} : {1'b0, div_q[k]};
            t  = VW'($signed({1'b0, qm}));
            if (div_neg[k])
            begin
                t = -t;
            end
            unique case (last.op)
                qau_pkg::FN_NORM:
                begin
                    fin[k] = (k == 0) ? VW'($signed({1'b0, root_mag})) : '0;
                end
                qau_pkg::FN_INV:
                begin
                    fin[k] = div_zero[0] ? '0 : t;
                end
                default:
                begin
                    fin[k] = $signed(last.val[k]);
                end
            endcase
            sat[k]  = sat32(fin[k]);
            any_sat = any_sat | sat[k].f;
        end
        priority if ((last.op == qau_pkg::FN_INV) && div_zero[0])
        begin
            status_next = qau_pkg::ST_ZERO;
        end
        else if (any_sat)
        begin
            status_next = qau_pkg::ST_SAT;
        end
        else
        begin
            status_next = qau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[qau_pkg::STG_OUT])
        begin
            r_w    <= sat[0].v;
            r_x    <= sat[1].v;
            r_y    <= sat[2].v;
            r_z    <= sat[3].v;
            status <= status_next;
        end
    end

endmodule

// ===== tb/quaternion_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the quaternion arithmetic unit. Every transaction that the
// unit accepts is run through a behavioural model of the arithmetic, and the predicted
// quaternion and status are queued. A monitor compares each result that leaves the unit
// with the oldest prediction, field by field. Both handshakes are throttled at random,
// in three phases of differing idle rates, so gaps fall on every stage of the pipeline.
module quaternion_arithmetic_unit_test;

    typedef struct {
        logic [3:0]         fn;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] s;
    } quat_op_t;

    typedef struct {
        logic signed [31:0] r [4];
        logic [1:0]         st;
    } quat_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         func;
    logic signed [31:0] a_w, a_x, a_y, a_z;
    logic signed [31:0] b_w, b_x, b_y, b_z;
    logic signed [31:0] scalar;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] r_w, r_x, r_y, r_z;
    logic [1:0]         status;

    // Predicted results, oldest first, and the running count of failures.
    quat_res_t pending_results [$];
    int        errors;

    // Percentages of cycles in which the sender and the receiver hold back.
    int send_idle;
    int recv_idle;

    quaternion_arithmetic_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .a_w       (a_w),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_w       (b_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .scalar    (scalar),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .r_w       (r_w),
        .r_x       (r_x),
        .r_y       (r_y),
        .r_z       (r_z),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Fixed-point product rounded to nearest with ties towards plus infinity. The
    // arithmetic shift of a signed value is a floor, which gives exactly that rounding.
    function automatic longint fx_mul(input longint p, input longint q);
        longint full;
        full = p * q + (64'sd1 <<< (qau_pkg::FRAC_BITS - 1));
        return full >>> qau_pkg::FRAC_BITS;
    endfunction

    // Clamps a wide lane value to 32 bits, noting any clipping in the flag.
    function automatic logic signed [31:0] clamp32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Bitwise integer square root over 32 steps.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem, root, bt;
        rem  = n;
        root = 0;
        bt   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= root + bt)
            begin
                rem  = rem - (root + bt);
                root = (root >> 1) + bt;
            end
            else
                root = root >> 1;
            bt = bt >> 2;
        end
        return root;
    endfunction

    function automatic quat_res_t quat_compute(input quat_op_t op);
        longint          a [4];
        longint          b [4];
        longint          s;
        longint          r [4];
        longint          n2, c;
        longint unsigned m, num, qt;
        logic [65:0]     sq_sum;
        bit              clipped;
        quat_res_t       res;
        for (int k = 0; k < 4; k++)
        begin
            a[k] = op.a[k];
            b[k] = op.b[k];
            r[k] = 0;
        end
        s       = op.s;
        clipped = 1'b0;
        res.st  = qau_pkg::ST_OK;
        case (op.fn)
            qau_pkg::FN_ADD:
                for (int k = 0; k < 4; k++)
                    r[k] = a[k] + b[k];
            qau_pkg::FN_SUB:
                for (int k = 0; k < 4; k++)
                    r[k] = a[k] - b[k];
            qau_pkg::FN_DOT:
                r[0] = -(fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]) + fx_mul(a[3], b[3]));
            qau_pkg::FN_CROSS:
            begin
                r[1] = fx_mul(a[2], b[3]) - fx_mul(b[2], a[3]);
                r[2] = fx_mul(a[3], b[1]) - fx_mul(b[3], a[1]);
                r[3] = fx_mul(a[1], b[2]) - fx_mul(b[1], a[2]);
            end
            qau_pkg::FN_SCALE:
                for (int k = 0; k < 4; k++)
                    r[k] = fx_mul(a[k], s);
            qau_pkg::FN_PROD:
            begin
                r[0] = fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
                     - fx_mul(a[2], b[2]) - fx_mul(a[3], b[3]);
                r[1] = fx_mul(a[0], b[1]) + fx_mul(a[1], b[0])
                     + fx_mul(a[2], b[3]) - fx_mul(a[3], b[2]);
                r[2] = fx_mul(a[0], b[2]) - fx_mul(a[1], b[3])
                     + fx_mul(a[2], b[0]) + fx_mul(a[3], b[1]);
                r[3] = fx_mul(a[0], b[3]) + fx_mul(a[1], b[2])
                     - fx_mul(a[2], b[1]) + fx_mul(a[3], b[0]);
            end
            qau_pkg::FN_CONJ:
            begin
                r[0] = a[0];
                for (int k = 1; k < 4; k++)
                    r[k] = -a[k];
            end
            qau_pkg::FN_NORM:
            begin
                sq_sum = '0;
                for (int k = 0; k < 4; k++)
                begin
                    m      = (a[k] < 0) ? -a[k] : a[k];
                    sq_sum = sq_sum + 66'(m * m);
                end
                // A sum that no longer fits 64 bits clips to the largest value.
                if (sq_sum[65:64] != 2'b00)
                begin
                    r[0]    = 64'sd2147483647;
                    clipped = 1'b1;
                end
                else
                    r[0] = int_sqrt(sq_sum[63:0]);
            end
            qau_pkg::FN_INV:
            begin
                n2 = 0;
                for (int k = 0; k < 4; k++)
                    n2 = n2 + fx_mul(a[k], a[k]);
                if (n2 == 0)
                    res.st = qau_pkg::ST_ZERO;
                else
                    for (int k = 0; k < 4; k++)
                    begin
                        c    = (k == 0) ? a[k] : -a[k];
                        m    = (c < 0) ? -c : c;
                        num  = m << qau_pkg::FRAC_BITS;
                        qt   = (num + (longint'(n2) >> 1)) / longint'(n2);
                        r[k] = (c < 0) ? -longint'(qt) : longint'(qt);
                    end
            end
            default:
                ;
        endcase
        for (int k = 0; k < 4; k++)
            res.r[k] = clamp32(r[k], clipped);
        if (res.st == qau_pkg::ST_OK && clipped)
            res.st = qau_pkg::ST_SAT;
        return res;
    endfunction

    // Presents one transaction and holds it until the unit takes it. Valid is only
    // lowered when the sender decides to idle, so back-to-back transactions never see
    // a low and a high on valid in the same time step.
    task automatic send_op(input quat_op_t op);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op.fn;
        a_w      <= op.a[0];
        a_x      <= op.a[1];
        a_y      <= op.a[2];
        a_z      <= op.a[3];
        b_w      <= op.b[0];
        b_x      <= op.b[1];
        b_y      <= op.b[2];
        b_z      <= op.b[3];
        scalar   <= op.s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(quat_compute(op));
    endtask

    function automatic quat_op_t make_op(input logic [3:0] fn,
                                         input logic signed [31:0] aw, ax, ay, az,
                                         input logic signed [31:0] bw, bx, by, bz,
                                         input logic signed [31:0] s);
        quat_op_t op;
        op.fn   = fn;
        op.a[0] = aw;
        op.a[1] = ax;
        op.a[2] = ay;
        op.a[3] = az;
        op.b[0] = bw;
        op.b[1] = bx;
        op.b[2] = by;
        op.b[3] = bz;
        op.s    = s;
        return op;
    endfunction

    // Operands: full-range noise, magnitudes up to 2.0 and 1024.0, tiny ones, extremes.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
            3:       return $signed($urandom_range(511)) - 32'sd256;
            4:       return $signed($urandom_range(32'h7ffffff)) - 32'sh4000000;
            default:
                case ($urandom_range(4))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sh00010000;
                endcase
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] mx, mn, one;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh00010000;
        // One of each operation on ordinary values.
        for (int f = 0; f <= 8; f++)
            send_op(make_op(4'(f), one, 32'sh00020000, -32'sh00018000, 32'sh00004000,
                            32'sh00008000, -one, 32'sh00030000, one, 32'sh00028000));
        // Extremes: sums and products that clip, with the all-ones pattern too.
        send_op(make_op(qau_pkg::FN_ADD, mx, mn, mx, -32'sd1, mx, mn, 32'sd1, mn, 32'sd0));
        send_op(make_op(qau_pkg::FN_SUB, mn, mx, 32'sd0, -32'sd1, mx, mn, mn, mx, 32'sd0));
        send_op(make_op(qau_pkg::FN_PROD, mn, mn, mx, mx, mn, mx, mn, mx, 32'sd0));
        send_op(make_op(qau_pkg::FN_SCALE, mx, mn, -32'sd1, one, 32'sd0, 32'sd0, 32'sd0,
                        32'sd0, mn));
        send_op(make_op(qau_pkg::FN_DOT, 32'sd0, mn, mn, mn, mx, mn, mn, mn, mx));
        send_op(make_op(qau_pkg::FN_CROSS, mx, mx, mn, mx, mn, mn, mx, mn, -32'sd1));
        // Negating the most negative component clips.
        send_op(make_op(qau_pkg::FN_CONJ, mn, mn, mx, 32'sd0, mx, mx, mx, mx, mx));
        // Norm whose sum of squares overflows 64 bits, and a norm of zero.
        send_op(make_op(qau_pkg::FN_NORM, mn, mn, mn, mn, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                        32'sd0));
        send_op(make_op(qau_pkg::FN_NORM, 32'sd0, 32'sd0, 32'sd0, 32'sd0, mx, mx, mx, mx,
                        mx));
        // Inverse of zero, of a tiny input whose squared norm rounds to zero, of a tiny
        // input with a large inverse, and of a large one.
        send_op(make_op(qau_pkg::FN_INV, 32'sd0, 32'sd0, 32'sd0, 32'sd0, mx, mn, mx, mn, mx));
        send_op(make_op(qau_pkg::FN_INV, 32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd0, 32'sd0,
                        32'sd0, 32'sd0, 32'sd0));
        send_op(make_op(qau_pkg::FN_INV, 32'sd200, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                        32'sd0, 32'sd0, 32'sd0));
        send_op(make_op(qau_pkg::FN_INV, mn, mx, mn, mx, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                        32'sd0));
        // Unused operation codes give zero with a good status.
        send_op(make_op(4'd9, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_op(make_op(4'd15, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    endtask

    task automatic test_random(input int count);
        quat_op_t op;
        for (int i = 0; i < count; i++)
        begin
            // Mostly real operations, with the unused codes now and again.
            if ($urandom_range(15) == 0)
                op.fn = 4'($urandom_range(15, 9));
            else
                op.fn = 4'($urandom_range(8));
            for (int k = 0; k < 4; k++)
            begin
                op.a[k] = pick_value();
                op.b[k] = pick_value();
            end
            op.s = pick_value();
            send_op(op);
        end
    endtask

    // Receiver throttling: ready is redrawn each cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // Result monitor: every accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        quat_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: %h %h %h %h status %0d",
                         $time, r_w, r_x, r_y, r_z, status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (r_w !== want.r[0])
                begin
                    errors++;
                    $display("%0t: r_w expected %h actual %h", $time, want.r[0], r_w);
                end
                if (r_x !== want.r[1])
                begin
                    errors++;
                    $display("%0t: r_x expected %h actual %h", $time, want.r[1], r_x);
                end
                if (r_y !== want.r[2])
                begin
                    errors++;
                    $display("%0t: r_y expected %h actual %h", $time, want.r[2], r_y);
                end
                if (r_z !== want.r[3])
                begin
                    errors++;
                    $display("%0t: r_z expected %h actual %h", $time, want.r[3], r_z);
                end
                if (status !== want.st)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
            end
        end
    end

    // Overall time limit, far above the slowest correct run.
    initial
    begin
        #4000000;
        $display("FAIL quaternion_arithmetic_unit");
        $finish;
    end

    initial
    begin
        int waited;
        errors    = 0;
        send_idle = 9;
        recv_idle = 84;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        func      = qau_pkg::FN_ADD;
        a_w       = '0;
        a_x       = '0;
        a_y       = '0;
        a_z       = '0;
        b_w       = '0;
        b_x       = '0;
        b_y       = '0;
        b_z       = '0;
        scalar    = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalling.
        test_directed();
        test_random(450);
        // Sender mostly idle, receiver mostly ready.
        send_idle = 84;
        recv_idle = 9;
        test_random(450);
        // Neither side holds back.
        send_idle = 0;
        recv_idle = 0;
        test_random(475);
        in_valid <= 1'b0;

        // Drain the pipeline, then keep watching for stray results.
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        if (errors == 0)
            $display("PASS quaternion_arithmetic_unit");
        else
            $display("FAIL quaternion_arithmetic_unit");
        $finish;
    end

endmodule
